// ----- sv/srig_pkg.sv -----
package srig_pkg;

    // Element count limit for lengths and available counts
    localparam int MAX_ELEMENTS = 64;

    // Restoring divider: 7-bit dividend, one quotient bit per cycle
    localparam int DIV_W     = 7;
    localparam int DIV_STEPS = DIV_W;

    // Job queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [1:0] REG_SLICE_START = 2'd0;
    localparam logic [1:0] REG_SLICE_STEP  = 2'd1;
    localparam logic [1:0] REG_SLICE_END   = 2'd2;

    typedef struct packed {
        logic signed [7:0] slice_start;
        logic [6:0]        slice_step;
        logic signed [7:0] slice_end;
    } cfg_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] quo;
    } div_state_t;

    typedef struct packed {
        logic [6:0] count;
        logic       empty;
        logic [5:0] dst0;
        logic [5:0] stepmod;
        logic [6:0] len;
    } job_t;

    // One restoring division step: shift in the next dividend bit, subtract if it fits
    function automatic div_state_t div_step(div_state_t x, logic [DIV_W-1:0] d);
        logic [DIV_W:0] t;
        div_state_t     y;
        t = {x.rem, x.quo[DIV_W-1]};
        if (t >= {1'b0, d}) begin
            y.rem = DIV_W'(t - {1'b0, d});
            y.quo = {x.quo[DIV_W-2:0], 1'b1};
        end else begin
            y.rem = t[DIV_W-1:0];
            y.quo = {x.quo[DIV_W-2:0], 1'b0};
        end
        return y;
    endfunction

endpackage

// ----- sv/srig_front.sv -----
module srig_front
    import srig_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [6:0] s_available,
    input  logic [6:0] s_array_length,
    input  logic [5:0] s_ring_offset,
    input  logic [6:0] s_request_count,
    output logic       job_valid,
    input  logic       job_ready,
    output job_t       job
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;
    localparam logic [2:0] LAST_ITER = 3'(DIV_STEPS - 1);
    localparam logic [6:0] MAX_LEN   = 7'(MAX_ELEMENTS);

    logic [1:0]  state_reg;
    logic [2:0]  iter_reg;
    div_state_t  div_a_reg;
    div_state_t  div_b_reg;
    div_state_t  div_c_reg;
    logic        nonempty_reg;
    logic [6:0]  req_reg;
    logic [6:0]  len_reg;
    logic [6:0]  step_reg;

    logic              accept;
    logic [6:0]        avail;
    logic [6:0]        len_in;
    logic [6:0]        step_eff;
    logic signed [8:0] avail9;
    logic signed [8:0] s_ext;
    logic signed [8:0] e_ext;
    logic signed [8:0] s_raw;
    logic signed [8:0] s_pos;
    logic signed [8:0] s_cl;
    logic signed [8:0] e_raw;
    logic signed [8:0] e_pos;
    logic signed [8:0] e_cl;
    logic signed [8:0] diff9;
    logic              nonempty;
    logic [6:0]        s_val;
    logic [6:0]        sum_b;

    logic [6:0] n_sel;
    logic [6:0] cnt_req;
    logic [6:0] cnt_len;
    logic       unit_case;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Saturate the incoming lengths and the configured step
    always_comb begin
        avail    = (s_available > MAX_LEN) ? MAX_LEN : s_available;
        len_in   = (s_array_length == 7'd0) ? 7'd1 :
                   ((s_array_length > MAX_LEN) ? MAX_LEN : s_array_length);
        step_eff = (cfg.slice_step == 7'd0) ? 7'd1 : cfg.slice_step;
    end

    // Resolve negative indexes and clamp start and end against the available count
    always_comb begin
        avail9 = signed'({2'b00, avail});
        s_ext  = signed'({cfg.slice_start[7], cfg.slice_start});
        e_ext  = signed'({cfg.slice_end[7], cfg.slice_end});
        s_raw  = cfg.slice_start[7] ? (avail9 + s_ext) : s_ext;
        s_pos  = (s_raw < 0) ? 9'sd0 : s_raw;
        s_cl   = (s_pos > avail9) ? avail9 : s_pos;
        e_raw  = cfg.slice_end[7] ? (avail9 + e_ext) : e_ext;
        e_pos  = (e_raw < 0) ? 9'sd0 : e_raw;
        e_cl   = (e_pos >= avail9) ? (avail9 - 9'sd1) : e_pos;
        nonempty = (e_cl >= s_cl);
        diff9  = e_cl - s_cl;
        s_val  = s_cl[6:0];
        sum_b  = {1'b0, s_ring_offset} + s_val;
    end

    // Control: accept, run the dividers, hand the job to the queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            iter_reg  <= 3'd0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_DIV;
                        iter_reg  <= 3'd0;
                    end
                end
                ST_DIV: begin
                    iter_reg <= iter_reg + 3'd1;
                    if (iter_reg == LAST_ITER) begin
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (job_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath: load operands on accept, one quotient bit per cycle after that
    always_ff @(posedge aclk) begin
        if (accept) begin
            div_a_reg    <= '{rem: '0, quo: diff9[6:0]};
            div_b_reg    <= '{rem: '0, quo: sum_b};
            div_c_reg    <= '{rem: '0, quo: step_eff};
            nonempty_reg <= nonempty;
            req_reg      <= s_request_count;
            len_reg      <= len_in;
            step_reg     <= step_eff;
        end else if (state_reg == ST_DIV) begin
            div_a_reg <= div_step(div_a_reg, step_reg);
            div_b_reg <= div_step(div_b_reg, len_reg);
            div_c_reg <= div_step(div_c_reg, len_reg);
        end
    end

    // Build the job: selected count, limits, start index and wrapped stride
    always_comb begin
        n_sel     = nonempty_reg ? (div_a_reg.quo + 7'd1) : 7'd0;
        cnt_req   = (req_reg < n_sel) ? req_reg : n_sel;
        cnt_len   = ((step_reg == 7'd1) && (cnt_req > len_reg)) ? len_reg : cnt_req;
        unit_case = (step_reg == 7'd1) && (len_reg == 7'd1);
        job.len     = len_reg;
        job.stepmod = div_c_reg.rem[5:0];
        if (unit_case) begin
            job.count = 7'd1;
            job.empty = 1'b0;
            job.dst0  = 6'd0;
        end else begin
            job.count = cnt_len;
            job.empty = (cnt_len == 7'd0);
            job.dst0  = (cnt_len == 7'd0) ? 6'd0 : div_b_reg.rem[5:0];
        end
    end

    assign job_valid = (state_reg == ST_PUSH);

endmodule

// ----- sv/srig_queue.sv -----
module srig_queue
    import srig_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != FULL_COUNT);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Track pointers and fill level; pointers wrap naturally at the power-of-two depth
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the job
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- sv/srig_back.sv -----
module srig_back
    import srig_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       job_valid,
    output logic       job_ready,
    input  job_t       job,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [5:0] m_source_index,
    output logic [5:0] m_dest_index,
    output logic       m_last,
    output logic       m_empty_res,
    output logic [6:0] m_transfer_count
);

    logic       busy_reg;
    job_t       job_reg;
    logic [5:0] idx_reg;
    logic [5:0] dst_reg;
    logic       m_valid_reg;
    logic [5:0] src_out_reg;
    logic [5:0] dst_out_reg;
    logic       last_out_reg;
    logic       empty_out_reg;
    logic [6:0] total_out_reg;

    logic       pop;
    logic       load_out;
    logic       is_last;
    logic [6:0] dst_sum;
    logic [5:0] dst_next;

    assign job_ready = !busy_reg;
    assign pop       = job_valid && job_ready;
    assign load_out  = busy_reg && (!m_valid_reg || m_ready);

    // Final element of the job, and the next ring position
    always_comb begin
        is_last  = job_reg.empty || (({1'b0, idx_reg} + 7'd1) == job_reg.count);
        dst_sum  = {1'b0, dst_reg} + {1'b0, job_reg.stepmod};
        dst_next = (dst_sum >= job_reg.len) ? 6'(dst_sum - job_reg.len) : dst_sum[5:0];
    end

    // Control: take a job when free, drop it after its last transaction is loaded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                busy_reg <= 1'b1;
            end else if (load_out && is_last) begin
                busy_reg <= 1'b0;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Walk source and destination indexes, fill the output register
    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= job;
            idx_reg <= 6'd0;
            dst_reg <= job.dst0;
        end else if (load_out) begin
            idx_reg <= idx_reg + 6'd1;
            dst_reg <= dst_next;
        end
        if (load_out) begin
            src_out_reg   <= idx_reg;
            dst_out_reg   <= dst_reg;
            last_out_reg  <= is_last;
            empty_out_reg <= job_reg.empty;
            total_out_reg <= job_reg.count;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_source_index   = src_out_reg;
    assign m_dest_index     = dst_out_reg;
    assign m_last           = last_out_reg;
    assign m_empty_res      = empty_out_reg;
    assign m_transfer_count = total_out_reg;

endmodule

// ----- sv/strided_ring_index_generator.sv -----
// Flow: an accepted request runs the 7-step restoring divider in the front, and
// its job goes through the queue to the back; the front takes no new request
// until the current job is pushed, and the back emits one result per cycle while
// m_ready holds and takes a new job only once the last result of a job is loaded.
// Reset: synchronous, active low; clears the control state and loads the slice
// registers with start 0, step 1, end -1.
module strided_ring_index_generator
    import srig_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [6:0] s_available,
    input  logic [6:0] s_array_length,
    input  logic [5:0] s_ring_offset,
    input  logic [6:0] s_request_count,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [5:0] m_source_index,
    output logic [5:0] m_dest_index,
    output logic       m_last,
    output logic       m_empty_res,
    output logic [6:0] m_transfer_count
);

    cfg_t cfg_reg;
    logic front_valid;
    logic front_ready;
    job_t front_job;
    logic back_valid;
    logic back_ready;
    job_t back_job;

    assign cfg_ready = 1'b1;

    // Slice registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slice_start <= 8'sd0;
            cfg_reg.slice_step  <= 7'd1;
            cfg_reg.slice_end   <= -8'sd1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SLICE_START: cfg_reg.slice_start <= signed'(cfg_data);
                REG_SLICE_STEP:  cfg_reg.slice_step  <= cfg_data[6:0];
                REG_SLICE_END:   cfg_reg.slice_end   <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    srig_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_available     (s_available),
        .s_array_length  (s_array_length),
        .s_ring_offset   (s_ring_offset),
        .s_request_count (s_request_count),
        .job_valid       (front_valid),
        .job_ready       (front_ready),
        .job             (front_job)
    );

    srig_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_job),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_data  (back_job)
    );

    srig_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .job_valid        (back_valid),
        .job_ready        (back_ready),
        .job              (back_job),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_source_index   (m_source_index),
        .m_dest_index     (m_dest_index),
        .m_last           (m_last),
        .m_empty_res      (m_empty_res),
        .m_transfer_count (m_transfer_count)
    );

endmodule

// ----- sv/srig_checker.sv -----
module srig_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [5:0] m_source_index,
    input logic [5:0] m_dest_index,
    input logic       m_last,
    input logic       m_empty_res,
    input logic [6:0] m_transfer_count
);

    // Hold a stalled result transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_source_index)
            && $stable(m_dest_index) && $stable(m_last) && $stable(m_transfer_count))
        else $error("stalled result transaction changed");

    // Empty result stands alone with zero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_empty_res |-> m_last && (m_transfer_count == 7'd0)
            && (m_source_index == 6'd0) && (m_dest_index == 6'd0))
        else $error("empty result malformed");

    // Source index stays inside the transfer count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_empty_res |-> (m_transfer_count != 7'd0)
            && ({1'b0, m_source_index} < m_transfer_count))
        else $error("source index beyond transfer count");

    // Last flag sits on the final source index
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_empty_res |->
            (m_last == (({1'b0, m_source_index} + 7'd1) == m_transfer_count)))
        else $error("last flag misplaced");

endmodule

bind strided_ring_index_generator srig_checker u_srig_checker (.*);
